[sv/lcd_page_framebuffer_flush_defines.svh]
// ----------------------------------------------------------------------------
// lcd_page_framebuffer_flush_defines.svh
// Assertion macros used by the checker file of the frame store block.
// ----------------------------------------------------------------------------
`ifndef LCD_PAGE_FRAMEBUFFER_FLUSH_DEFINES_SVH
`define LCD_PAGE_FRAMEBUFFER_FLUSH_DEFINES_SVH

// Property checked on every rising edge, suspended while reset is high.
`define LPF_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define LPF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/lpf_pkg.sv]
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared constants, types and codes of the page frame store and flush block.
// ----------------------------------------------------------------------------
package lpf_pkg;

  // Display geometry.
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_ROWS     = 8;
  localparam int NUM_PAGES     = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_SIZE    = NUM_PAGES * SCREEN_WIDTH;

  // Field and index widths.
  localparam int COORD_W = 16;
  localparam int ADDR_W  = $clog2(STORE_SIZE);
  localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int COL_W   = $clog2(SCREEN_WIDTH);
  localparam int BIT_W   = $clog2(PAGE_ROWS);

  // Page transmission: three header bytes, then one data byte per column.
  localparam int HEADER_LEN = 3;
  localparam int POS_W      = $clog2(SCREEN_WIDTH + HEADER_LEN);
  localparam int LAST_POS   = HEADER_LEN + SCREEN_WIDTH - 1;

  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_COL_LO = 8'h00;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = CFG_IDX_W'(1);

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Input command codes.
  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FLUSH = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_PIX_WR,
    BK_TICK_DATA
  } back_state_e;

  // One classified command as it travels through the queue.
  typedef struct packed {
    op_e               op;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  col;
    logic [BIT_W-1:0]  bit_sel;
    logic              value;
  } queue_entry_t;

endpackage

[sv/lpf_front.sv]
// ----------------------------------------------------------------------------
// lpf_front
// Input side: origin registers, coordinate offset and clipping, queue fill.
// ----------------------------------------------------------------------------
module lpf_front import lpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // Input item channel.
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           command,
  input  logic [COORD_W-1:0]   x_coord,
  input  logic [COORD_W-1:0]   y_coord,
  input  logic                 pixel_value,
  // Queue write side and back-end status.
  output logic                 q_wr,
  output queue_entry_t         q_entry,
  input  logic                 q_full,
  input  logic                 sweeping
);

  logic [COORD_W-1:0] x_origin;
  logic [COORD_W-1:0] y_origin;
  logic [COORD_W-1:0] x_off;
  logic [COORD_W-1:0] y_off;
  logic               on_screen;
  op_e                op;

  // Origin registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= '0;
      y_origin <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_X_ORIGIN: x_origin <= cfg_data;
        CFG_Y_ORIGIN: y_origin <= cfg_data;
        default: ;
      endcase
    end
  end

  // Offset with a 16-bit wrap, then clip against the screen.
  assign x_off     = x_coord + x_origin;
  assign y_off     = y_coord + y_origin;
  assign on_screen = (x_off < COORD_W'(SCREEN_WIDTH)) && (y_off < COORD_W'(SCREEN_HEIGHT));
  assign op        = op_e'(command);

  // The input stalls while the queue is full or the store is being swept.
  assign full = q_full || sweeping;

  // Off-screen pixel writes are dropped here and never reach the queue.
  assign q_wr = push && !full && ((op != OP_PIXEL) || on_screen);

  always_comb begin
    q_entry.op      = op;
    q_entry.page    = PAGE_W'(y_off >> BIT_W);
    q_entry.col     = COL_W'(x_off);
    q_entry.bit_sel = y_off[BIT_W-1:0];
    q_entry.value   = pixel_value;
  end

endmodule

[sv/lpf_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// lpf_cmd_fifo
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module lpf_cmd_fifo import lpf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  queue_entry_t wr_data,
  input  logic         rd_en,
  output queue_entry_t rd_data,
  output logic         fifo_full,
  output logic         fifo_empty
);

  queue_entry_t           slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign fifo_full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign fifo_empty = (count == '0);
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && !fifo_empty;
  assign rd_data    = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/lpf_back.sv]
// ----------------------------------------------------------------------------
// lpf_back
// Back end: frame store memory, dirty pages, flush sequencer, result register.
// ----------------------------------------------------------------------------
module lpf_back import lpf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // Queue read side.
  input  queue_entry_t head,
  input  logic         q_empty,
  output logic         q_pop,
  output logic         sweeping,
  // Result channel.
  output logic         empty,
  input  logic         pop,
  output logic [7:0]   out_byte,
  output logic         is_data,
  output logic         last_of_flush
);

  back_state_e state;
  back_state_e state_next;

  // Frame store and its registered read port.
  logic [7:0]        mem [STORE_SIZE];
  logic [7:0]        rd_data;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  // Flush state.
  logic [NUM_PAGES-1:0] dirty;
  logic                 active;
  logic [PAGE_W-1:0]    page;
  logic [POS_W-1:0]     pos;
  logic                 tick_last;

  // Pixel write in progress and sweep counter.
  queue_entry_t      cur;
  logic [ADDR_W-1:0] clr_addr;

  // Result register.
  logic out_valid;
  logic out_free;

  // Decode helpers.
  logic            head_valid;
  logic            is_header;
  logic            at_end;
  logic [PAGE_W:0] first_dirty;
  logic [PAGE_W:0] next_dirty;
  logic            next_found;
  logic [7:0]      header_byte;
  logic [7:0]      pix_mask;
  logic [7:0]      pix_new;

  // Lowest dirty page at or above 'from'; NUM_PAGES when there is none.
  function automatic logic [PAGE_W:0] find_from(logic [NUM_PAGES-1:0] bits,
                                                logic [PAGE_W:0] from);
    logic [PAGE_W:0] res;
    res = (PAGE_W + 1)'(NUM_PAGES);
    for (int p = NUM_PAGES - 1; p >= 0; p--) begin
      if (bits[p] && ((PAGE_W + 1)'(p) >= from)) begin
        res = (PAGE_W + 1)'(p);
      end
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(logic [PAGE_W-1:0] pg,
                                                   logic [COL_W-1:0] col);
    return ADDR_W'(pg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
  endfunction

  assign head_valid  = !q_empty;
  assign out_free    = !out_valid || pop;
  assign is_header   = (pos < POS_W'(HEADER_LEN));
  assign at_end      = (pos == POS_W'(LAST_POS));
  assign first_dirty = find_from(dirty, '0);
  assign next_dirty  = find_from(dirty, (PAGE_W + 1)'(page) + 1'b1);
  assign next_found  = (next_dirty < (PAGE_W + 1)'(NUM_PAGES));
  assign sweeping    = (state == BK_SWEEP);
  assign pix_mask    = 8'(1) << cur.bit_sel;
  assign pix_new     = cur.value ? (rd_data | pix_mask) : (rd_data & ~pix_mask);

  // Header byte for the current position.
  always_comb begin
    if (pos == POS_W'(0)) begin
      header_byte = CMD_PAGE | (8'(page) & 8'h07);
    end else if (pos == POS_W'(1)) begin
      header_byte = CMD_COL_HI;
    end else begin
      header_byte = CMD_COL_LO;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_SWEEP: begin
        if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid) begin
          unique case (head.op)
            OP_PIXEL: state_next = BK_PIX_WR;
            OP_CLEAR: state_next = BK_SWEEP;
            OP_FLUSH: state_next = BK_IDLE;
            OP_TICK: begin
              if (active && out_free && !is_header) begin
                state_next = BK_TICK_DATA;
              end
            end
          endcase
        end
      end
      BK_PIX_WR:    state_next = BK_IDLE;
      BK_TICK_DATA: state_next = BK_IDLE;
    endcase
  end

  // Queue pop and memory port control.
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    unique case (state)
      BK_SWEEP: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      BK_IDLE: begin
        if (head_valid) begin
          // A tick during a flush waits until the result register is free.
          q_pop = (head.op != OP_TICK) || !active || out_free;
          if (head.op == OP_PIXEL) begin
            mem_re   = 1'b1;
            mem_addr = store_addr(head.page, head.col);
          end else if (head.op == OP_TICK && active && out_free && !is_header) begin
            mem_re   = 1'b1;
            mem_addr = store_addr(page, COL_W'(pos - POS_W'(HEADER_LEN)));
          end
        end
      end
      BK_PIX_WR: begin
        mem_we    = 1'b1;
        mem_addr  = store_addr(cur.page, cur.col);
        mem_wdata = pix_new;
      end
      BK_TICK_DATA: ;
    endcase
  end

  // Frame store: one access per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Pixel write operands held for the write-back cycle.
  always_ff @(posedge clk) begin
    if (q_pop && head.op == OP_PIXEL) begin
      cur <= head;
    end
  end

  // State, sweep counter, dirty pages and flush position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_SWEEP;
      clr_addr  <= '0;
      dirty     <= '0;
      active    <= 1'b0;
      page      <= '0;
      pos       <= '0;
      tick_last <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_SWEEP) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == BK_PIX_WR && pix_new != rd_data) begin
        dirty[cur.page] <= 1'b1;
      end
      if (q_pop) begin
        unique case (head.op)
          OP_PIXEL: ;
          OP_CLEAR: begin
            clr_addr <= '0;
            dirty    <= '1;
            active   <= 1'b1;
            page     <= '0;
            pos      <= '0;
          end
          OP_FLUSH: begin
            if (!active && first_dirty < (PAGE_W + 1)'(NUM_PAGES)) begin
              active <= 1'b1;
              page   <= PAGE_W'(first_dirty);
              pos    <= '0;
            end
          end
          OP_TICK: begin
            if (active) begin
              // The page leaves the dirty set as its first header byte goes out.
              if (pos == POS_W'(0)) begin
                dirty[page] <= 1'b0;
              end
              tick_last <= at_end && !next_found;
              if (at_end) begin
                pos <= '0;
                if (next_found) begin
                  page <= PAGE_W'(next_dirty);
                end else begin
                  active <= 1'b0;
                  page   <= '0;
                end
              end else begin
                pos <= pos + 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == BK_TICK_DATA) ||
                 (q_pop && head.op == OP_TICK && active && is_header)) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: header bytes at dispatch, data bytes after the read.
  always_ff @(posedge clk) begin
    if (state == BK_TICK_DATA) begin
      out_byte      <= rd_data;
      is_data       <= 1'b1;
      last_of_flush <= tick_last;
    end else if (q_pop && head.op == OP_TICK && active && is_header) begin
      out_byte      <= header_byte;
      is_data       <= 1'b0;
      last_of_flush <= 1'b0;
    end
  end

  assign empty = !out_valid;

endmodule

[sv/lcd_page_framebuffer_flush.sv]
// ----------------------------------------------------------------------------
// lcd_page_framebuffer_flush
// Monochrome page frame store with dirty-page flush to a display link.
// ----------------------------------------------------------------------------
// Commands enter through a queue-style port (push/full) and results leave
// through another (empty/pop). Origin registers are written on the cfg
// channel, which is always ready; index 0 is the x origin, index 1 the y
// origin, other indexes are ignored. Write them only while the block is idle.
// A front stage offsets and clips pixel writes and feeds a four-entry command
// queue; the back end owns the single-port frame store and the flush state.
// Pixel writes take a read, then a write, in the back end. A flush request
// and a tick outside a flush are handled in the idle state alone, as is a
// header tick, which loads its byte into the result register; a data tick
// first reads the frame store, then loads the byte in the tick-data state.
// These extra steps come from the one read/write port of the frame store.
// After reset, and after every clear command, the store is swept to zero at
// one byte per cycle; full stays high until all 1024 store bytes are zero.
// While the receiver does not pop, the result register holds its byte and a
// tick during a flush waits at the queue head; once the queue fills, full
// rises.
// ----------------------------------------------------------------------------
module lcd_page_framebuffer_flush import lpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // Input item channel.
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           command,
  input  logic [COORD_W-1:0]   x_coord,
  input  logic [COORD_W-1:0]   y_coord,
  input  logic                 pixel_value,
  // Result channel.
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 is_data,
  output logic                 last_of_flush
);

  queue_entry_t q_wr_entry;
  queue_entry_t q_head;
  logic         q_wr;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  logic         sweeping;

  // Classification and origin offset.
  lpf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .command     (command),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .pixel_value (pixel_value),
    .q_wr        (q_wr),
    .q_entry     (q_wr_entry),
    .q_full      (q_full),
    .sweeping    (sweeping)
  );

  // Command queue between the two sides.
  lpf_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (q_wr),
    .wr_data    (q_wr_entry),
    .rd_en      (q_pop),
    .rd_data    (q_head),
    .fifo_full  (q_full),
    .fifo_empty (q_empty)
  );

  // Frame store, flush sequencer and result register.
  lpf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .sweeping      (sweeping),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .is_data       (is_data),
    .last_of_flush (last_of_flush)
  );

endmodule

[sv/lpf_checker.sv]
// ----------------------------------------------------------------------------
// lpf_checker
// Port-level checks of the frame store block, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcd_page_framebuffer_flush_defines.svh"

module lpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       is_data,
  input logic       last_of_flush
);

  // Reset leaves no result waiting.
  `LPF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result pending after reset")

  // The store sweep after reset holds off input.
  `LPF_ASSERT_ALWAYS(a_reset_full, clk, rst |=> full, "input accepted during reset sweep")

  // A waiting result holds until it is taken.
  `LPF_ASSERT_CLK(a_hold, clk, rst,
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(is_data) &&
    $stable(last_of_flush)), "result changed while stalled")

  // The flush always ends on a data byte, and command bytes are address commands.
  `LPF_ASSERT_CLK(a_cmd_bytes, clk, rst,
    (!empty && !is_data) |-> (!last_of_flush && (out_byte[7:4] == 4'hB ||
    out_byte == 8'h10 || out_byte == 8'h00)), "malformed command byte")

endmodule

bind lcd_page_framebuffer_flush lpf_checker u_lpf_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_byte      (out_byte),
  .is_data       (is_data),
  .last_of_flush (last_of_flush)
);

[verif/lcd_page_framebuffer_flush_test.sv]
// ----------------------------------------------------------------------------
// lcd_page_framebuffer_flush_test
// Self-checking testbench for the page frame store and dirty-page flush block.
// ----------------------------------------------------------------------------
// A short table of directed commands runs first. It covers off-screen pixels,
// idle ticks, ignored flush requests, writes during a flush, the page order
// and a clear that aborts a page. Random bursts follow: pixel writes on a few
// pages, a flush request, then mostly ticks until the flush ends. They run
// under several origin settings. Every link byte is compared with its typed-in
// table byte or with a shadow of the frame store and flush state kept here.
// ----------------------------------------------------------------------------
module lcd_page_framebuffer_flush_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpf_pkg::*;

  // Run lengths and limits, in clock cycles unless noted.
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 1100;  // covers the store sweep after a clear
  localparam int TAIL_CYCLES   = 50;
  localparam int LONG_HOLD     = 300;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 60;    // counted commands per origin setting
  localparam int DIRECTED_ROWS = 26;

  // An index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(9);

  // One byte on the display link.
  typedef struct packed {
    logic [7:0] value;
    logic       data;
    logic       last;
  } link_byte_t;

  // One row of the directed table; a known row carries its byte typed in.
  typedef struct {
    op_e         op;
    logic [15:0] x;
    logic [15:0] y;
    logic        pv;
    int          reps;
    bit          known;
    logic [7:0]  k_byte;
    logic        k_data;
    logic        k_last;
  } step_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 push;
  logic                 full;
  logic [1:0]           command;
  logic [COORD_W-1:0]   x_coord;
  logic [COORD_W-1:0]   y_coord;
  logic                 pixel_value;
  logic                 empty;
  logic                 pop;
  logic [7:0]           out_byte;
  logic                 is_data;
  logic                 last_of_flush;

  // Shadow of the block's state and origin registers.
  logic [7:0]           shadow_store [STORE_SIZE];
  logic [NUM_PAGES-1:0] shadow_dirty;
  bit                   shadow_active;
  int                   shadow_page;
  int                   shadow_pos;
  logic [15:0]          shadow_xorg;
  logic [15:0]          shadow_yorg;

  // Link bytes still owed by the block, oldest first.
  link_byte_t expected_bytes[$];

  int  errors;
  int  items_counted;
  int  bytes_checked;
  int  clears_sent;
  int  reg_writes;
  int  cycle_count;
  bit  calm;
  bit  hold_request;

  step_row_t directed_steps [DIRECTED_ROWS] = '{
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_FLUSH, 16'd0,     16'd0,     1'b0, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_PIXEL, 16'd0,     16'd0,     1'b1, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_PIXEL, 16'd127,   16'd63,    1'b1, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_PIXEL, 16'd128,   16'd0,     1'b1, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_PIXEL, 16'd0,     16'd64,    1'b1, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_PIXEL, 16'hFFFF,  16'hFFFF,  1'b1, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_PIXEL, 16'd0,     16'd0,     1'b1, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_FLUSH, 16'd0,     16'd0,     1'b0, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_FLUSH, 16'd0,     16'd0,     1'b0, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1,    1'b1, 8'hB0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1,    1'b1, 8'h10, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1,    1'b1, 8'h00, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1,    1'b1, 8'h01, 1'b1, 1'b0},
    '{OP_PIXEL, 16'd0,     16'd0,     1'b0, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_PIXEL, 16'd5,     16'd62,    1'b1, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 127,  1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1,    1'b1, 8'hB7, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 129,  1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1,    1'b1, 8'h80, 1'b1, 1'b1},
    '{OP_FLUSH, 16'd0,     16'd0,     1'b0, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1,    1'b1, 8'hB0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 5,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_CLEAR, 16'd0,     16'd0,     1'b0, 1,    1'b0, 8'h00, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1,    1'b1, 8'hB0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1047, 1'b0, 8'h00, 1'b0, 1'b0}
  };

  lcd_page_framebuffer_flush DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .command       (command),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .pixel_value   (pixel_value),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .is_data       (is_data),
    .last_of_flush (last_of_flush)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Lowest dirty page at or above from_page, or NUM_PAGES if there is none.
  function automatic int next_dirty(input int from_page);
    int p;
    for (p = from_page; p < NUM_PAGES; p++) begin
      if (shadow_dirty[p]) return p;
    end
    return NUM_PAGES;
  endfunction

  // Applies one command to the shadow state. Returns whether the command had
  // any effect; a tick during a flush also yields the byte it sends.
  function automatic bit apply_item(input op_e op, input logic [15:0] xc,
                                    input logic [15:0] yc, input logic pv,
                                    output bit produced, output link_byte_t lb);
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  mask;
    logic [7:0]  old_b;
    logic [7:0]  new_b;
    int          pg;
    int          idx;
    int          nxt;
    bit          effective;
    effective = 1'b1;
    produced  = 1'b0;
    lb        = '0;
    case (op)
      OP_PIXEL: begin
        // Offsets wrap at 16 bits; anything off the screen is dropped.
        px = xc + shadow_xorg;
        py = yc + shadow_yorg;
        if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT) begin
          effective = 1'b0;
        end else begin
          pg    = py / PAGE_ROWS;
          mask  = 8'(1 << (py % PAGE_ROWS));
          idx   = pg * SCREEN_WIDTH + px;
          old_b = shadow_store[idx];
          new_b = pv ? (old_b | mask) : (old_b & ~mask);
          shadow_store[idx] = new_b;
          if (old_b != new_b) shadow_dirty[pg] = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
        shadow_dirty  = '1;
        shadow_active = 1'b1;
        shadow_page   = 0;
        shadow_pos    = 0;
      end
      OP_FLUSH: begin
        nxt = next_dirty(0);
        if (!shadow_active && nxt < NUM_PAGES) begin
          shadow_active = 1'b1;
          shadow_page   = nxt;
          shadow_pos    = 0;
        end else begin
          effective = 1'b0;
        end
      end
      default: begin
        if (!shadow_active) begin
          effective = 1'b0;
        end else begin
          // Three address bytes, then one data byte per column.
          produced = 1'b1;
          if (shadow_pos == 0) begin
            lb.value = CMD_PAGE | 8'(shadow_page);
            shadow_dirty[shadow_page] = 1'b0;
          end else if (shadow_pos == 1) begin
            lb.value = CMD_COL_HI;
          end else if (shadow_pos == 2) begin
            lb.value = CMD_COL_LO;
          end else begin
            lb.value = shadow_store[shadow_page * SCREEN_WIDTH + shadow_pos - HEADER_LEN];
            lb.data  = 1'b1;
          end
          if (shadow_pos == LAST_POS) begin
            nxt = next_dirty(shadow_page + 1);
            if (nxt < NUM_PAGES) begin
              shadow_page = nxt;
            end else begin
              shadow_active = 1'b0;
              shadow_page   = 0;
              lb.last       = 1'b1;
            end
            shadow_pos = 0;
          end else begin
            shadow_pos++;
          end
        end
      end
    endcase
    return effective;
  endfunction

  // Offers one command until it is taken, then updates the shadow state.
  task automatic send_item(input op_e op, input logic [15:0] xc, input logic [15:0] yc,
                           input logic pv, input bit known, input link_byte_t typed);
    link_byte_t lb;
    bit         produced;
    bit         effective;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push        <= 1'b1;
    command     <= op;
    x_coord     <= xc;
    y_coord     <= yc;
    pixel_value <= pv;
    do @(posedge clk); while (full);
    effective = apply_item(op, xc, yc, pv, produced, lb);
    if (produced) expected_bytes.push_back(known ? typed : lb);
    if (effective) items_counted++;
    if (op == OP_CLEAR) clears_sent++;
    @(negedge clk);
  endtask

  // Pixel write that lands on the given page under the current origin.
  task automatic send_pixel(input int page);
    logic [15:0] tx;
    logic [15:0] ty;
    tx = 16'($urandom_range(0, SCREEN_WIDTH - 1));
    ty = 16'(page * PAGE_ROWS + $urandom_range(0, PAGE_ROWS - 1));
    send_item(OP_PIXEL, tx - shadow_xorg, ty - shadow_yorg,
              1'($urandom_range(0, 9) < 7), 1'b0, '0);
  endtask

  // Stops offering commands until every owed byte has been taken.
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (expected_bytes.size() != 0);
  endtask

  // Register write; the caller makes sure the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_X_ORIGIN) shadow_xorg = value;
    else if (idx == CFG_Y_ORIGIN) shadow_yorg = value;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // A burst: a few writes on one or two pages, a flush request, then mostly
  // ticks with writes and noise, until the flush ends or the quota is met.
  task automatic run_burst(input bit with_hold, input int quota_end);
    int page_a;
    int page_b;
    int n;
    int k;
    int r;
    page_a = $urandom_range(0, NUM_PAGES - 1);
    page_b = $urandom_range(0, NUM_PAGES - 1);
    n      = $urandom_range(1, 10);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_item(OP_PIXEL, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
      else if (r == 1) send_item(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
      else send_pixel(k[0] ? page_a : page_b);
    end
    send_item(OP_FLUSH, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
    if (with_hold) hold_request = 1'b1;
    while (shadow_active && items_counted < quota_end) begin
      r = $urandom_range(0, 999);
      if (r < 850) send_item(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
      else if (r < 960) send_pixel($urandom_range(0, NUM_PAGES - 1));
      else if (r < 990) send_item(OP_FLUSH, 16'($urandom), 16'($urandom), 1'b0, 1'b0, '0);
      else if (r < 999) send_item(OP_PIXEL, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
      else send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
    end
  endtask

  // Receiver side: random short stalls, and one long hold-off on request.
  initial begin
    int stall;
    int held;
    pop   = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(negedge clk);
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(0, 3);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Each transfer on the result side is checked against the oldest owed byte.
  always @(posedge clk) begin : check_link
    link_byte_t want;
    if (!rst && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: byte with none owed: expected nothing, got %02h data %0b last %0b",
                 $time, out_byte, is_data, last_of_flush);
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_byte !== want.value) begin
          errors++;
          $display("%0t: out_byte expected %02h, got %02h", $time, want.value, out_byte);
        end
        if (is_data !== want.data) begin
          errors++;
          $display("%0t: is_data expected %0b, got %0b", $time, want.data, is_data);
        end
        if (last_of_flush !== want.last) begin
          errors++;
          $display("%0t: last_of_flush expected %0b, got %0b", $time, want.last,
                   last_of_flush);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("%0t: timeout with %0d bytes still owed", $time, expected_bytes.size());
    $display("lcd_page_framebuffer_flush_test NOT OK");
    $finish;
  end

  // Main stimulus.
  initial begin
    logic [15:0] phase_xorg [PHASES];
    logic [15:0] phase_yorg [PHASES];
    link_byte_t  typed;
    int          row;
    int          k;
    int          ph;
    int          quota_end;
    int          bursts;
    phase_xorg = '{16'h0000, 16'hFFFF, 16'd100, 16'h0000, 16'h8000};
    phase_yorg = '{16'h0000, 16'hFFFF, 16'd60,  16'h0000, 16'h0007};
    rst          = 1'b1;
    push         = 1'b0;
    command      = OP_TICK;
    x_coord      = '0;
    y_coord      = '0;
    pixel_value  = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    errors        = 0;
    items_counted = 0;
    bytes_checked = 0;
    clears_sent   = 0;
    reg_writes    = 0;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    shadow_dirty  = '0;
    shadow_active = 1'b0;
    shadow_page   = 0;
    shadow_pos    = 0;
    shadow_xorg   = '0;
    shadow_yorg   = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table, run at the reset origin.
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      typed = '{value: directed_steps[row].k_byte, data: directed_steps[row].k_data,
                last: directed_steps[row].k_last};
      for (k = 0; k < directed_steps[row].reps; k++) begin
        send_item(directed_steps[row].op, directed_steps[row].x, directed_steps[row].y,
                  directed_steps[row].pv, directed_steps[row].known, typed);
      end
    end

    // Random bursts under each origin setting; the last phase runs without
    // idling on either side.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clk);
      if (ph == 3) begin
        phase_xorg[ph] = 16'($urandom);
        phase_yorg[ph] = 16'($urandom);
      end
      if (ph == PHASES - 1) calm = 1'b1;
      write_reg(CFG_X_ORIGIN, phase_xorg[ph]);
      write_reg(CFG_Y_ORIGIN, phase_yorg[ph]);
      if (ph == 0) write_reg(CFG_SPARE, 16'hFFFF);
      quota_end = items_counted + PHASE_ITEMS;
      bursts    = 0;
      while (items_counted < quota_end) begin
        run_burst(ph == 0 && bursts == 0, quota_end);
        bursts++;
        // Sender pauses once mid-phase until the link has caught up.
        if (ph == 2 && bursts == 1) wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Covered %0d effective commands, %0d link bytes, %0d clears, %0d register writes",
             items_counted, bytes_checked, clears_sent, reg_writes);
    $display("over %0d origin settings with %0d mismatches.", PHASES, errors);
    if (errors == 0) begin
      $display("lcd_page_framebuffer_flush_test OK");
    end else begin
      $display("lcd_page_framebuffer_flush_test NOT OK");
    end
    $finish;
  end

endmodule
